/* design/swtq_pkg.sv */
// swtq_pkg: types, codes and defaults shared by the sorted wake-up timer queue
// used by every module of the block but swtq_ram, and by its port checker
`default_nettype none

package swtq_pkg;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // most wake results that one tick request may give
    localparam int MAX_RESULTS     = 16;

    // field widths fixed by the interface
    localparam int TICK_W  = 63;
    localparam int WAKE_W  = 64;
    localparam int SLEEP_W = 32;
    localparam int IDF_W   = 8;

    // request kinds
    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED     = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_FULL       = 3'd2,
        ST_WOKEN      = 3'd3,
        ST_NONE_WOKEN = 3'd4
    } status_t;

    typedef struct packed {
        logic                      req_type;
        logic [IDF_W-1:0]          requester_id;
        logic signed [SLEEP_W-1:0] sleep_ticks;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [IDF_W-1:0]   woken_id;
        logic [TICK_W-1:0]  current_tick;
        logic               last;
    } res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_WAKE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic ins_step;
        logic wake_step;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_tick;
        logic go_insert;
        logic ins_last;
        logic wake_due;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/swtq_ram.sv */
// swtq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/swtq_ctrl.sv */
// swtq_ctrl: sequencer for the timer queue, steps the insert walk and the wake scan
// depends on swtq_pkg
`default_nettype none

module swtq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire swtq_pkg::dp_stat_t stat,
    output swtq_pkg::ctl_cmd_t      cmd
);

    import swtq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.go_tick)
                    begin
                        state_next = S_WAKE;
                    end
                    else if (stat.go_insert)
                    begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                if (stat.ins_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WAKE:
            begin
                if (!stat.wake_due)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        cmd.load      = start && (state_reg == S_IDLE);
        cmd.ins_step  = (state_reg == S_INSERT);
        cmd.wake_step = (state_reg == S_WAKE);
    end

endmodule

`default_nettype wire

/* design/swtq_datapath.sv */
// swtq_datapath: tick counter, circular sorted queue in RAM, and result register
// depends on swtq_pkg and swtq_ram
`default_nettype none

module swtq_datapath #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = swtq_pkg::ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swtq_pkg::req_t     request,
    input  wire swtq_pkg::ctl_cmd_t cmd,
    output swtq_pkg::dp_stat_t      stat,
    output logic                    strobe,
    output swtq_pkg::res_t          result
);

    import swtq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = WAKE_W + ID_BITS;
    localparam int LIM   = (MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH;
    localparam logic [CNT_W:0]   DEPTH_W = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] K_LIM   = CNT_W'(LIM);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

    // queue position relative to head, to RAM address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] rel);
        logic [CNT_W:0] sum;
        begin
            sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, rel};
            if (sum >= DEPTH_W)
            begin
                sum = sum - DEPTH_W;
            end
            phys = sum[IDX_W-1:0];
        end
    endfunction

    logic [TICK_W-1:0]  tick_reg,       tick_next;
    logic [IDX_W-1:0]   head_reg,       head_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [CNT_W-1:0]   cur_reg,        cur_next;
    logic [WAKE_W-1:0]  wake_reg,       wake_next;
    logic [ID_BITS-1:0] id_reg,         id_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0] pend_id_reg,    pend_id_next;
    logic               strobe_reg,     strobe_next;
    res_t               result_reg,     result_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    logic [WAKE_W-1:0]  rd_wake;
    logic [ID_BITS-1:0] rd_id;
    logic               sleep_pos;
    logic               full;

    swtq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_wake = ram_rdata[ID_BITS +: WAKE_W];
    assign rd_id   = ram_rdata[ID_BITS-1:0];

    // request decode and step conditions
    always_comb
    begin
        sleep_pos      = (request.sleep_ticks != '0) && !request.sleep_ticks[SLEEP_W-1];
        full           = (count_reg == FULL_C);
        stat.go_tick   = (request.req_type == REQ_TICK);
        stat.go_insert = (request.req_type == REQ_SLEEP) && sleep_pos && !full;
        stat.ins_last  = (cur_reg == '0) || (rd_wake <= wake_reg);
        stat.wake_due  = (cur_reg < count_reg) && (cur_reg < K_LIM)
                         && (rd_wake <= {1'b0, tick_reg});
    end

    // datapath next values
    always_comb
    begin
        tick_next       = tick_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        wake_next       = wake_reg;
        id_next         = id_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_waddr       = phys(head_reg, cur_reg);
        ram_wdata       = ram_rdata;
        ram_raddr       = phys(head_reg, '0);

        priority if (cmd.load)
        begin
            wake_next = {1'b0, tick_reg}
                        + {{(WAKE_W - SLEEP_W){1'b0}}, $unsigned(request.sleep_ticks)};
            id_next   = ID_BITS'(request.requester_id);
            if (stat.go_tick)
            begin
                // tick: bump counter and fetch the head entry
                tick_next       = tick_reg + TICK_W'(1);
                cur_next        = '0;
                pend_valid_next = 1'b0;
            end
            else if (stat.go_insert)
            begin
                // insert: walk from the tail towards the head
                cur_next = count_reg;
                if (count_reg != '0)
                begin
                    ram_raddr = phys(head_reg, count_reg - ONE_C);
                end
            end
            else
            begin
                // rejected sleep request answers at once
                strobe_next              = 1'b1;
                result_next.status       = sleep_pos ? ST_FULL : ST_IGNORED;
                result_next.woken_id     = '0;
                result_next.current_tick = tick_reg;
                result_next.last         = 1'b1;
            end
        end
        else if (cmd.ins_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_reg, cur_reg);
            if (stat.ins_last)
            begin
                // new entry lands behind every equal or earlier wake time
                ram_wdata                = {wake_reg, id_reg};
                count_next               = count_reg + ONE_C;
                strobe_next              = 1'b1;
                result_next.status       = ST_QUEUED;
                result_next.woken_id     = '0;
                result_next.current_tick = tick_reg;
                result_next.last         = 1'b1;
            end
            else
            begin
                // move the later entry one place back
                ram_wdata = ram_rdata;
                cur_next  = cur_reg - ONE_C;
                if (cur_reg >= TWO_C)
                begin
                    ram_raddr = phys(head_reg, cur_reg - TWO_C);
                end
            end
        end
        else if (cmd.wake_step)
        begin
            if (stat.wake_due)
            begin
                // hold this id back until it is known whether it is the last
                if (pend_valid_reg)
                begin
                    strobe_next              = 1'b1;
                    result_next.status       = ST_WOKEN;
                    result_next.woken_id     = IDF_W'(pend_id_reg);
                    result_next.current_tick = tick_reg;
                    result_next.last         = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = rd_id;
                cur_next        = cur_reg + ONE_C;
                ram_raddr       = phys(head_reg, cur_reg + ONE_C);
            end
            else
            begin
                // scan over: drop woken entries from the head
                strobe_next              = 1'b1;
                result_next.status       = pend_valid_reg ? ST_WOKEN : ST_NONE_WOKEN;
                result_next.woken_id     = pend_valid_reg ? IDF_W'(pend_id_reg) : '0;
                result_next.current_tick = tick_reg;
                result_next.last         = 1'b1;
                head_next                = phys(head_reg, cur_reg);
                count_next               = count_reg - cur_reg;
            end
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        wake_reg    <= wake_next;
        id_reg      <= id_next;
        pend_id_reg <= pend_id_next;
        result_reg  <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* design/sorted_wakeup_timer_queue.sv */
// sorted_wakeup_timer_queue: top level, joins the sequencer and the datapath
// depends on swtq_pkg, swtq_ctrl, swtq_datapath
//
// Usage
//   request channel: a request is taken at a rising edge where start is high
//   and busy is low. A sleep request queues requester_id to wake at
//   current tick + sleep_ticks, after any entry with the same wake time; a
//   zero or negative count is answered as ignored, a full queue as full.
//   A tick request adds one to the 63-bit counter and wakes due entries from
//   the head, at most 16 of them, one result each, the last one marked.
//   result channel: strobe is high for one cycle per result; the receiver
//   cannot stall it, so results must be taken as they come.
//   A rejected sleep request answers in the cycle after it is taken.
//   An accepted sleep request walks the queue tail to head in the RAM, one
//   entry per cycle, up to the insert point, then writes the new entry.
//   A tick request scans from the head one entry a cycle, with woken
//   results spread over consecutive cycles.
//   busy is high while the walk or scan runs; the next request may be taken
//   in the cycle that the final result is shown.
//   Reset: counter and queue empty; the queue RAM itself is not cleared.
`default_nettype none

module sorted_wakeup_timer_queue #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = swtq_pkg::ID_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire swtq_pkg::req_t request,
    output logic                strobe,
    output swtq_pkg::res_t      result
);

    import swtq_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer
    swtq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // queue storage and arithmetic
    swtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

`default_nettype wire

/* design/swtq_checker.sv */
// swtq_checker: port-level checks on result sequencing of the timer queue
// depends on swtq_pkg; bound to sorted_wakeup_timer_queue
`default_nettype none

module swtq_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire swtq_pkg::req_t request,
    input wire logic           strobe,
    input wire swtq_pkg::res_t result
);

    import swtq_pkg::*;

    // a result that is not the last is followed at once by another
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("result burst broken before last");

    // only wake results can be non-last
    a_nonlast_is_woken: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> result.status == ST_WOKEN)
        else $error("non-last result is not a wake result");

    // results of one request share the tick value
    a_tick_steady: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> result.current_tick == $past(result.current_tick))
        else $error("tick changed within one request");

    // nonpositive sleep request answers next cycle as ignored
    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.req_type == REQ_SLEEP
        && (request.sleep_ticks == '0 || request.sleep_ticks[SLEEP_W-1])
        |=> strobe && result.last && result.status == ST_IGNORED)
        else $error("nonpositive sleep not answered as ignored");

    // the block is free again when the final result shows
    a_free_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("busy while final result shown");

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// testbench: self-checking bench for sorted_wakeup_timer_queue
// holds its own model of the tick counter and the sorted sleep queue
// depends on swtq_pkg and the design sources only
`default_nettype none

module testbench;
    import swtq_pkg::*;

    localparam int QDEPTH          = QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_REQUESTS = 160;
    localparam int TAIL_CYCLES     = 40;

    // tracks the tick counter and the wake order, holds the results still owed
    class wakeup_book;
        logic [TICK_W-1:0] tick_now;
        logic [WAKE_W-1:0] wake_at[$];
        logic [IDF_W-1:0]  owner[$];
        res_t              awaited[$];
        int errors;
        int requests;
        int queued;
        int ignored;
        int rejected;
        int woken;
        int empty_ticks;
        int widest_burst;

        function new();
            tick_now     = '0;
            errors       = 0;
            requests     = 0;
            queued       = 0;
            ignored      = 0;
            rejected     = 0;
            woken        = 0;
            empty_ticks  = 0;
            widest_burst = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // entries far enough out that they will never wake during the run
        function int far_entries();
            int n;
            n = 0;
            foreach (wake_at[i])
                if (wake_at[i] > {1'b0, tick_now} + 64'd1000)
                    n++;
            return n;
        endfunction

        // work out the results owed for an accepted request
        function void take_request(req_t r);
            logic signed [SLEEP_W-1:0] count;
            logic [WAKE_W-1:0]         wake;
            res_t                      e;
            int                        pos;
            int                        due;
            requests++;
            e      = '0;
            e.last = 1'b1;
            if (r.req_type == REQ_SLEEP)
            begin
                count = r.sleep_ticks;
                if (count <= 0)
                begin
                    e.status = ST_IGNORED;
                    ignored++;
                end
                else if (wake_at.size() >= QDEPTH)
                begin
                    e.status = ST_FULL;
                    rejected++;
                end
                else
                begin
                    // goes in behind every entry due at the same time or earlier
                    wake = {1'b0, tick_now} + {32'd0, count};
                    pos  = 0;
                    while (pos < wake_at.size() && wake_at[pos] <= wake)
                        pos++;
                    wake_at.insert(pos, wake);
                    owner.insert(pos, r.requester_id);
                    e.status = ST_QUEUED;
                    queued++;
                end
                e.current_tick = tick_now;
                awaited.push_back(e);
            end
            else
            begin
                tick_now       = tick_now + 1'b1;
                e.current_tick = tick_now;
                due            = 0;
                while (due < wake_at.size() && due < MAX_RESULTS &&
                       wake_at[due] <= {1'b0, tick_now})
                    due++;
                if (due == 0)
                begin
                    e.status = ST_NONE_WOKEN;
                    empty_ticks++;
                    awaited.push_back(e);
                end
                else
                begin
                    // due entries leave from the head in queue order
                    for (int i = 0; i < due; i++)
                    begin
                        e.status   = ST_WOKEN;
                        e.woken_id = owner.pop_front();
                        void'(wake_at.pop_front());
                        e.last     = (i == due - 1);
                        awaited.push_back(e);
                    end
                    woken += due;
                    if (due > widest_burst)
                        widest_burst = due;
                end
            end
        endfunction

        // compare a strobed result with the oldest one owed
        function void check_result(res_t got);
            res_t e;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d id %0d tick %0d last %0b",
                             got.status, got.woken_id, got.current_tick, got.last);
            end
            else
            begin
                e = awaited.pop_front();
                if (got.status !== e.status || got.woken_id !== e.woken_id ||
                    got.current_tick !== e.current_tick || got.last !== e.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected status %0d id %0d tick %0d last %0b",
                                 e.status, e.woken_id, e.current_tick, e.last);
                        $display("          got      status %0d id %0d tick %0d last %0b",
                                 got.status, got.woken_id, got.current_tick, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       start   = 1'b0;
    req_t       request = '0;
    logic       busy;
    logic       strobe;
    res_t       result;
    wakeup_book book;
    int         idle_cycles = 0;

    sorted_wakeup_timer_queue i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    // clock
    always #2 clk = ~clk;

    // monitor: results first, since a request may be taken as the last one shows
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                book.check_result(result);
            if (start && !busy)
                book.take_request(request);
        end
    end

    // watchdog on cycles where neither side moves anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    function automatic req_t sleep_req(input logic [IDF_W-1:0] id,
                                       input logic [SLEEP_W-1:0] ticks);
        req_t r;
        r.req_type     = REQ_SLEEP;
        r.requester_id = id;
        r.sleep_ticks  = ticks;
        return r;
    endfunction

    // tick request with noise in the unused fields
    function automatic req_t tick_req();
        req_t r;
        r.req_type     = REQ_TICK;
        r.requester_id = IDF_W'($urandom_range(0, 255));
        r.sleep_ticks  = $urandom;
        return r;
    endfunction

    // mostly short sleeps so entries keep waking; a few far-off ones, kept scarce
    function automatic req_t random_request(input bit lean_sleep);
        int          pick;
        logic [31:0] ticks;
        pick = $urandom_range(0, 99);
        if (pick < (lean_sleep ? 25 : 55))
            return tick_req();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            ticks = 32'd0;
        else if (pick < 10)
            ticks = 32'h8000_0000 | $urandom;
        else if (pick < 13 && book.far_entries() < 3)
            ticks = 32'h4000_0000 | ($urandom & 32'h3FFF_FFFF);
        else if (pick < 80)
            ticks = $urandom_range(1, 6);
        else
            ticks = $urandom_range(7, 40);
        return sleep_req(IDF_W'($urandom_range(0, 255)), ticks);
    endfunction

    // mostly back to back, some short gaps, a few long ones; none when calm
    function automatic int pick_gap(input bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present a request and hold it until an edge where busy is low
    task automatic put_request(input req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic send(input req_t r, input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        put_request(r);
    endtask

    // stop sending until every owed result has arrived
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        bit lean_sleep;
        bit calm;
        lean_sleep = 1'b0;
        calm       = 1'b0;
        book       = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero and negative counts, then a tick on an empty queue
        send(sleep_req(8'h00, 32'd0), 1'b0);
        send(sleep_req(8'hFF, 32'h8000_0000), 1'b0);
        send(sleep_req(8'h5A, 32'hFFFF_FFFF), 1'b0);
        send(tick_req(), 1'b0);

        // fill the queue with one shared wake time, then overfill it
        for (int i = 0; i < QDEPTH; i++)
            send(sleep_req(8'(i * 17), 32'd2), 1'b0);
        send(sleep_req(8'h77, 32'd5), 1'b0);
        send(sleep_req(8'h33, 32'd0), 1'b0);

        // the whole queue falls due on one tick
        send(tick_req(), 1'b0);
        send(tick_req(), 1'b0);
        send(tick_req(), 1'b0);

        // largest count stays queued for good, shortest one wakes next tick
        send(sleep_req(8'hC3, 32'h7FFF_FFFF), 1'b0);
        send(sleep_req(8'h01, 32'd1), 1'b0);
        send(tick_req(), 1'b0);
        settle();

        // random mix, switching between sleep-heavy and tick-heavy spells
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                lean_sleep = !lean_sleep;
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            if ($urandom_range(0, 39) == 0)
                settle();
            send(random_request(lean_sleep), calm);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d queued, %0d ignored, %0d refused as full",
                 book.requests, book.queued, book.ignored, book.rejected);
        $display("summary: %0d woken, %0d empty ticks, widest burst %0d, %0d mismatches",
                 book.woken, book.empty_ticks, book.widest_burst, book.errors);
        if (book.errors == 0 && book.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
